/* hdl/kta_pkg.sv */
`default_nettype none
package kta_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int TRAIL_DEPTH   = 32;

	localparam int SLOT_W   = $clog2(TABLE_ENTRIES);
	localparam int HEAD_W   = $clog2(TRAIL_DEPTH);
	localparam int FILL_W   = $clog2(TRAIL_DEPTH + 1);
	localparam int CNT_W    = $clog2(TABLE_ENTRIES + 1);
	localparam int TRAIL_AW = $clog2(TABLE_ENTRIES * TRAIL_DEPTH);

	localparam int KEY_W   = 24;
	localparam int TIME_W  = 32;
	localparam int LAT_W   = 31;
	localparam int LON_W   = 32;
	localparam int ALT_W   = 18;
	localparam int ALPHA_W = 9;
	localparam int CFG_W   = 20;
	localparam int QUO_W   = 8;

	localparam int IN_TDATA_W  = 144;
	localparam int OUT_TDATA_W = 64;

	localparam logic [SLOT_W-1:0]  LAST_SLOT      = SLOT_W'(TABLE_ENTRIES - 1);
	localparam logic [HEAD_W-1:0]  LAST_HEAD      = HEAD_W'(TRAIL_DEPTH - 1);
	localparam logic [FILL_W-1:0]  FILL_MAX       = FILL_W'(TRAIL_DEPTH);
	localparam logic [ALPHA_W-1:0] ALPHA_ONE      = 9'd256;
	localparam logic [CFG_W-1:0]   DEFAULT_WINDOW = 20'd1000;
	localparam logic [CFG_W-1:0]   MAX_AGE_RST    = 20'd60000;
	localparam logic [CFG_W-1:0]   FADE_START_RST = 20'd30000;

	// register indexes
	localparam logic REG_MAX_AGE    = 1'b0;
	localparam logic REG_FADE_START = 1'b1;

	// result status codes
	localparam logic [2:0] ST_UPDATED  = 3'd0;
	localparam logic [2:0] ST_INSERTED = 3'd1;
	localparam logic [2:0] ST_DROPPED  = 3'd2;
	localparam logic [2:0] ST_LIVE     = 3'd3;
	localparam logic [2:0] ST_EXPIRED  = 3'd4;
	localparam logic [2:0] ST_IDLE     = 3'd5;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [TIME_W-1:0]  upd;
		logic [ALPHA_W-1:0] alpha;
		logic [HEAD_W-1:0]  head;
		logic [FILL_W-1:0]  fill;
	} entry_t;

	typedef struct packed {
		logic [TIME_W-1:0] ts;
		logic [ALT_W-1:0]  alt;
		logic [LON_W-1:0]  lon;
		logic [LAT_W-1:0]  lat;
	} trail_t;

	localparam int ENTRY_W = $bits(entry_t);
	localparam int TRAIL_W = $bits(trail_t);

endpackage
`default_nettype wire

/* hdl/kta_ram.sv */
`default_nettype none
module kta_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] waddr,
	input  wire logic [W-1:0]         wdata,
	input  wire logic                 re,
	input  wire logic [$clog2(D)-1:0] raddr,
	output logic      [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

/* hdl/kta_div.sv */
`default_nettype none
// Restoring divider: quo = floor(num * 2^QUO_W / den), needs num < den.
module kta_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [kta_pkg::CFG_W-1:0]   num,
	input  wire logic [kta_pkg::CFG_W-1:0]   den,
	output logic                             done,
	output logic      [kta_pkg::QUO_W-1:0]   quo
);

	logic                          busy_q;
	logic [$clog2(kta_pkg::QUO_W)-1:0] cnt_q;
	logic [kta_pkg::CFG_W-1:0]     rem_q;
	logic [kta_pkg::CFG_W-1:0]     den_q;
	logic [kta_pkg::QUO_W-1:0]     quo_q;
	logic                          done_q;
	logic [kta_pkg::CFG_W:0]       rem2;
	logic                          ge;

	assign rem2 = {rem_q, 1'b0};
	assign ge   = rem2 >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ($clog2(kta_pkg::QUO_W))'(kta_pkg::QUO_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			// one quotient bit per cycle
			rem_q <= ge ? kta_pkg::CFG_W'(rem2 - {1'b0, den_q}) : kta_pkg::CFG_W'(rem2);
			quo_q <= {quo_q[kta_pkg::QUO_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule
`default_nettype wire

/* hdl/keyed_track_table_with_aging_core.sv */
`default_nettype none
// Keyed track table with aging: 64 tracked targets keyed by a 24-bit address.
// Input words arrive on s_axis (tuser selects report or age sweep) and each
// is taken only while the core is between items; results leave on m_axis
// through one output register, so the next input word can be taken while
// the last result still waits. A report gives one result: the table read
// port scans one slot per cycle and stops at the first active key match.
// A sweep gives one result per slot, tlast on the final one: a first pass
// reads, ages and writes back each live slot, waiting on the fade divider
// when the slot is fading, and a second pass reads each slot again to emit
// it. A stall on m_axis_tready holds the core in its emit step; nothing is
// lost. Reset clears the active flags, counters and registers to their
// defaults; the table and trail memories need no clearing pass.
// Configuration writes are taken on any cycle and should be made while the
// core is idle.
module keyed_track_table_with_aging_core (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	// key[23:0], with_pos[24], latitude[55:25], longitude[87:56],
	// altitude_ft[105:88], time_ms[137:106], zero pad
	input  wire logic [kta_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// func
	input  wire logic                               s_axis_tuser,
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	// slot[5:0], alpha[14:6], trail_count[20:15], active_count[27:21],
	// seen_total[59:28], zero pad
	output logic      [kta_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	// status
	output logic      [2:0]                         m_axis_tuser,
	output logic                                    m_axis_tlast,
	input  wire logic                               cfg_we,
	input  wire logic                               cfg_addr,
	input  wire logic [kta_pkg::CFG_W-1:0]          cfg_wdata
);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_RSCAN = 9'b000000010,
		S_RUPD  = 9'b000000100,
		S_ROUT  = 9'b000001000,
		S_SRD   = 9'b000010000,
		S_SEV   = 9'b000100000,
		S_SDIV  = 9'b001000000,
		S_ERD   = 9'b010000000,
		S_EOUT  = 9'b100000000
	} state_t;

	state_t state_q;

	logic [kta_pkg::CFG_W-1:0]  max_age_q, fade_q;
	logic [kta_pkg::KEY_W-1:0]  key_q;
	logic                       hp_q;
	logic [kta_pkg::LAT_W-1:0]  lat_q;
	logic [kta_pkg::LON_W-1:0]  lon_q;
	logic [kta_pkg::ALT_W-1:0]  alt_q;
	logic [kta_pkg::TIME_W-1:0] time_q;

	logic [kta_pkg::TABLE_ENTRIES-1:0] active_q, expired_q;
	logic [kta_pkg::CNT_W-1:0]  live_q;
	logic [31:0]                seen_q;

	logic [kta_pkg::SLOT_W-1:0] scan_q, slot_q, tgt_q, slot_s1;
	logic                       issue_q, chk_s1, ins_q;
	kta_pkg::entry_t            ent_q;

	logic [2:0]                 res_status_q;
	logic [kta_pkg::SLOT_W-1:0] res_slot_q;
	logic [kta_pkg::ALPHA_W-1:0] res_alpha_q;
	logic [kta_pkg::FILL_W-1:0] res_fill_q;

	logic                       ovalid_q, olast_q;
	logic [2:0]                 ostatus_q;
	logic [5:0]                 oslot_q, ofill_q;
	logic [8:0]                 oalpha_q;
	logic [6:0]                 olive_q;
	logic [31:0]                oseen_q;
	logic                       out_free;

	// entry memory ports
	logic                       ent_re, ent_we;
	logic [kta_pkg::SLOT_W-1:0] ent_raddr, ent_waddr;
	kta_pkg::entry_t            ent_rdata, ent_wdata;

	logic                       trl_we;
	logic [kta_pkg::TRAIL_AW-1:0] trl_waddr;
	kta_pkg::trail_t            trl_wdata;

	// scan and sweep decode
	logic                       key_hit, scan_end, free_ok;
	logic [kta_pkg::SLOT_W-1:0] free_idx;
	logic [kta_pkg::TIME_W-1:0] age, age_off;
	logic                       is_exp, is_fading, slot_live;
	logic [kta_pkg::CFG_W-1:0]  window;
	logic                       div_start, div_done;
	logic [kta_pkg::QUO_W-1:0]  div_quo;

	// report write-back
	logic [kta_pkg::HEAD_W-1:0] base_head, new_head;
	logic [kta_pkg::FILL_W-1:0] base_fill, new_fill;

	assign s_axis_tready = (state_q == S_IDLE);
	assign out_free      = !ovalid_q || m_axis_tready;

	always_comb begin
		free_ok  = |(~active_q);
		free_idx = '0;
		for (int i = kta_pkg::TABLE_ENTRIES - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				free_idx = kta_pkg::SLOT_W'(i);
			end
		end
	end

	assign key_hit  = chk_s1 && active_q[slot_s1] && (ent_rdata.key == key_q);
	assign scan_end = chk_s1 && (slot_s1 == kta_pkg::LAST_SLOT);

	assign window    = (max_age_q > fade_q) ? (max_age_q - fade_q) : kta_pkg::DEFAULT_WINDOW;
	assign age       = time_q - ent_rdata.upd;
	assign age_off   = age - {12'd0, fade_q};
	assign is_exp    = age >= {12'd0, max_age_q};
	assign is_fading = age >= {12'd0, fade_q};
	assign slot_live = active_q[slot_q];
	assign div_start = (state_q == S_SEV) && slot_live && !is_exp && is_fading;

	assign base_head = ins_q ? '0 : ent_q.head;
	assign base_fill = ins_q ? '0 : ent_q.fill;
	assign new_head  = !hp_q ? base_head :
		(base_head == kta_pkg::LAST_HEAD) ? '0 : base_head + 1'b1;
	assign new_fill  = (hp_q && base_fill < kta_pkg::FILL_MAX) ? base_fill + 1'b1 : base_fill;

	always_comb begin
		ent_re    = 1'b0;
		ent_raddr = slot_q;
		ent_we    = 1'b0;
		ent_waddr = slot_q;
		ent_wdata = ent_rdata;
		unique case (state_q)
			S_RSCAN: begin
				ent_re    = issue_q;
				ent_raddr = scan_q;
			end
			S_RUPD: begin
				ent_we          = 1'b1;
				ent_waddr       = tgt_q;
				ent_wdata.key   = key_q;
				ent_wdata.upd   = time_q;
				ent_wdata.alpha = kta_pkg::ALPHA_ONE;
				ent_wdata.head  = new_head;
				ent_wdata.fill  = new_fill;
			end
			S_SRD, S_ERD: begin
				ent_re = 1'b1;
			end
			S_SEV: begin
				if (slot_live && is_exp) begin
					// expiry drops the trail
					ent_we         = 1'b1;
					ent_wdata.head = '0;
					ent_wdata.fill = '0;
				end else if (slot_live && !is_fading) begin
					ent_we          = 1'b1;
					ent_wdata.alpha = kta_pkg::ALPHA_ONE;
				end
			end
			S_SDIV: begin
				ent_we          = div_done;
				ent_wdata       = ent_q;
				ent_wdata.alpha = kta_pkg::ALPHA_ONE - {1'b0, div_quo};
			end
			default: begin
			end
		endcase
	end

	assign trl_we    = (state_q == S_RUPD) && hp_q;
	assign trl_waddr = kta_pkg::TRAIL_AW'(kta_pkg::TRAIL_AW'(tgt_q) *
		kta_pkg::TRAIL_AW'(kta_pkg::TRAIL_DEPTH)) + kta_pkg::TRAIL_AW'(base_head);
	assign trl_wdata = '{ts: time_q, alt: alt_q, lon: lon_q, lat: lat_q};

	kta_ram #(
		.W(kta_pkg::ENTRY_W),
		.D(kta_pkg::TABLE_ENTRIES)
	) u_entry_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wdata),
		.re    (ent_re),
		.raddr (ent_raddr),
		.rdata (ent_rdata)
	);

	kta_ram #(
		.W(kta_pkg::TRAIL_W),
		.D(kta_pkg::TABLE_ENTRIES * kta_pkg::TRAIL_DEPTH)
	) u_trail_ram (
		.clk   (clk),
		.we    (trl_we),
		.waddr (trl_waddr),
		.wdata (trl_wdata),
		.re    (1'b0),
		.raddr ('0),
		.rdata ()
	);

	kta_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (kta_pkg::CFG_W'(age_off)),
		.den    (window),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_age_q <= kta_pkg::MAX_AGE_RST;
			fade_q    <= kta_pkg::FADE_START_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				kta_pkg::REG_MAX_AGE:    max_age_q <= cfg_wdata;
				kta_pkg::REG_FADE_START: fade_q    <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			key_q  <= s_axis_tdata[23:0];
			hp_q   <= s_axis_tdata[24];
			lat_q  <= s_axis_tdata[55:25];
			lon_q  <= s_axis_tdata[87:56];
			alt_q  <= s_axis_tdata[105:88];
			time_q <= s_axis_tdata[137:106];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			active_q     <= '0;
			expired_q    <= '0;
			live_q       <= '0;
			seen_q       <= '0;
			scan_q       <= '0;
			slot_q       <= '0;
			tgt_q        <= '0;
			slot_s1      <= '0;
			issue_q      <= 1'b0;
			chk_s1       <= 1'b0;
			ins_q        <= 1'b0;
			res_status_q <= kta_pkg::ST_UPDATED;
			res_slot_q   <= '0;
			res_alpha_q  <= '0;
			res_fill_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						slot_q    <= '0;
						scan_q    <= '0;
						issue_q   <= 1'b1;
						chk_s1    <= 1'b0;
						expired_q <= '0;
						state_q   <= s_axis_tuser ? S_SRD : S_RSCAN;
					end
				end
				S_RSCAN: begin
					chk_s1  <= issue_q;
					slot_s1 <= scan_q;
					if (issue_q) begin
						if (scan_q == kta_pkg::LAST_SLOT) begin
							issue_q <= 1'b0;
						end else begin
							scan_q <= scan_q + 1'b1;
						end
					end
					if (key_hit) begin
						ent_q   <= ent_rdata;
						tgt_q   <= slot_s1;
						ins_q   <= 1'b0;
						state_q <= S_RUPD;
					end else if (scan_end) begin
						if (free_ok) begin
							tgt_q   <= free_idx;
							ins_q   <= 1'b1;
							state_q <= S_RUPD;
						end else begin
							res_status_q <= kta_pkg::ST_DROPPED;
							res_slot_q   <= '0;
							res_alpha_q  <= '0;
							res_fill_q   <= '0;
							state_q      <= S_ROUT;
						end
					end
				end
				S_RUPD: begin
					if (ins_q) begin
						active_q[tgt_q] <= 1'b1;
						live_q          <= live_q + 1'b1;
						seen_q          <= seen_q + 1'b1;
					end
					res_status_q <= ins_q ? kta_pkg::ST_INSERTED : kta_pkg::ST_UPDATED;
					res_slot_q   <= tgt_q;
					res_alpha_q  <= kta_pkg::ALPHA_ONE;
					res_fill_q   <= new_fill;
					state_q      <= S_ROUT;
				end
				S_ROUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_SRD: begin
					state_q <= S_SEV;
				end
				S_SEV: begin
					if (div_start) begin
						ent_q   <= ent_rdata;
						state_q <= S_SDIV;
					end else begin
						if (slot_live && is_exp) begin
							active_q[slot_q]  <= 1'b0;
							expired_q[slot_q] <= 1'b1;
							live_q            <= live_q - 1'b1;
						end
						if (slot_q == kta_pkg::LAST_SLOT) begin
							slot_q  <= '0;
							state_q <= S_ERD;
						end else begin
							slot_q  <= slot_q + 1'b1;
							state_q <= S_SRD;
						end
					end
				end
				S_SDIV: begin
					if (div_done) begin
						if (slot_q == kta_pkg::LAST_SLOT) begin
							slot_q  <= '0;
							state_q <= S_ERD;
						end else begin
							slot_q  <= slot_q + 1'b1;
							state_q <= S_SRD;
						end
					end
				end
				S_ERD: begin
					state_q <= S_EOUT;
				end
				S_EOUT: begin
					if (out_free) begin
						if (slot_q == kta_pkg::LAST_SLOT) begin
							slot_q  <= '0;
							state_q <= S_IDLE;
						end else begin
							slot_q  <= slot_q + 1'b1;
							state_q <= S_ERD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// load a new word, else drop the old one once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if ((state_q == S_ROUT || state_q == S_EOUT) && out_free) begin
			ovalid_q <= 1'b1;
		end else if (m_axis_tready) begin
			ovalid_q <= 1'b0;
		end
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (state_q == S_ROUT && out_free) begin
			ostatus_q <= res_status_q;
			oslot_q   <= 6'(res_slot_q);
			oalpha_q  <= res_alpha_q;
			ofill_q   <= 6'(res_fill_q);
			olive_q   <= 7'(live_q);
			oseen_q   <= seen_q;
			olast_q   <= 1'b1;
		end else if (state_q == S_EOUT && out_free) begin
			ostatus_q <= slot_live ? kta_pkg::ST_LIVE :
				(expired_q[slot_q] ? kta_pkg::ST_EXPIRED : kta_pkg::ST_IDLE);
			oslot_q   <= 6'(slot_q);
			oalpha_q  <= slot_live ? ent_rdata.alpha : '0;
			ofill_q   <= slot_live ? 6'(ent_rdata.fill) : '0;
			olive_q   <= 7'(live_q);
			oseen_q   <= seen_q;
			olast_q   <= (slot_q == kta_pkg::LAST_SLOT);
		end
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tuser  = ostatus_q;
	assign m_axis_tlast  = olast_q;
	assign m_axis_tdata  = {4'd0, oseen_q, olive_q, ofill_q, oalpha_q, oslot_q};

	a_live_matches: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(active_q) == int'(live_q))
		else $error("live count out of step with active flags");

	a_div_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_SDIV)
		else $error("fade divider finished outside its wait state");

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		ent_we |-> (state_q == S_RUPD || state_q == S_SEV || state_q == S_SDIV))
		else $error("table write outside an update step");

	a_no_read_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUPD) |=> !ent_re)
		else $error("table read right after report write");

endmodule
`default_nettype wire

/* verif/keyed_track_table_with_aging_core_chk.sv */
`timescale 1ns / 100ps
module keyed_track_table_with_aging_core_chk
	import kta_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_axis_tvalid,
	input  wire logic                   s_axis_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input  wire logic                   s_axis_tuser,
	input  wire logic                   m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	input  wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input  wire logic [2:0]             m_axis_tuser,
	input  wire logic                   m_axis_tlast,
	input  wire logic                   cfg_we,
	input  wire logic                   cfg_addr,
	input  wire logic [CFG_W-1:0]       cfg_wdata,
	output int                          fail_count,
	output int                          pending_results
);

	typedef struct packed {
		logic [2:0]         status;
		logic [SLOT_W-1:0]  slot;
		logic [ALPHA_W-1:0] alpha;
		logic [FILL_W-1:0]  fill;
		logic [CNT_W-1:0]   live;
		logic [31:0]        seen;
		logic               last;
	} track_result_t;

	track_result_t expected_results[$];

	logic [CFG_W-1:0]   max_age, fade_start;
	logic               active [TABLE_ENTRIES];
	logic [KEY_W-1:0]   keys   [TABLE_ENTRIES];
	logic [TIME_W-1:0]  upd_ms [TABLE_ENTRIES];
	logic [ALPHA_W-1:0] alphas [TABLE_ENTRIES];
	logic [FILL_W-1:0]  fills  [TABLE_ENTRIES];
	logic [CNT_W-1:0]   live_cnt;
	logic [31:0]        seen_cnt;

	assign pending_results = expected_results.size();

	task automatic predict_report(input logic [IN_TDATA_W-1:0] d);
		logic [KEY_W-1:0] k;
		int hit, free_s;
		track_result_t r;
		k = d[23:0];
		hit = -1;
		free_s = -1;
		for (int s = 0; s < TABLE_ENTRIES; s++) begin
			if (!active[s]) begin
				if (free_s < 0) free_s = s;
			end else if (hit < 0 && keys[s] == k) begin
				hit = s;
			end
		end
		r = '0;
		r.last = 1'b1;
		if (hit >= 0) begin
			r.status = ST_UPDATED;
		end else if (free_s >= 0) begin
			hit = free_s;
			r.status = ST_INSERTED;
			active[hit] = 1'b1;
			keys[hit] = k;
			fills[hit] = '0;
			live_cnt++;
			seen_cnt++;
		end else begin
			r.status = ST_DROPPED;
		end
		if (hit >= 0) begin
			upd_ms[hit] = d[137:106];
			alphas[hit] = ALPHA_ONE;
			if (d[24] && fills[hit] < FILL_MAX) fills[hit]++;
			r.slot = SLOT_W'(hit);
			r.alpha = alphas[hit];
			r.fill = fills[hit];
		end
		r.live = live_cnt;
		r.seen = seen_cnt;
		expected_results.push_back(r);
	endtask

	task automatic predict_sweep(input logic [TIME_W-1:0] now);
		logic [31:0] window, age;
		logic [63:0] fade_drop;
		logic [2:0] st [TABLE_ENTRIES];
		track_result_t r;
		int n;
		window = (max_age > fade_start) ? max_age - fade_start : DEFAULT_WINDOW;
		n = 0;
		for (int s = 0; s < TABLE_ENTRIES; s++) begin
			if (!active[s]) begin
				st[s] = ST_IDLE;
			end else begin
				age = now - upd_ms[s];
				if (age >= max_age) begin
					active[s] = 1'b0;
					fills[s] = '0;
					st[s] = ST_EXPIRED;
				end else begin
					if (age >= fade_start) begin
						fade_drop = (64'(age - fade_start) * 256) / window;
						alphas[s] = (fade_drop >= 256) ? '0 : ALPHA_W'(256 - fade_drop);
					end else begin
						alphas[s] = ALPHA_ONE;
					end
					st[s] = ST_LIVE;
					n++;
				end
			end
		end
		live_cnt = CNT_W'(n);
		for (int s = 0; s < TABLE_ENTRIES; s++) begin
			r.status = st[s];
			r.slot = SLOT_W'(s);
			r.alpha = (st[s] == ST_LIVE) ? alphas[s] : '0;
			r.fill = (st[s] == ST_LIVE) ? fills[s] : '0;
			r.live = live_cnt;
			r.seen = seen_cnt;
			r.last = (s == TABLE_ENTRIES - 1);
			expected_results.push_back(r);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_age <= MAX_AGE_RST;
			fade_start <= FADE_START_RST;
			for (int s = 0; s < TABLE_ENTRIES; s++) begin
				active[s] <= 1'b0;
				fills[s] <= '0;
			end
			live_cnt <= '0;
			seen_cnt <= '0;
			fail_count <= 0;
			expected_results.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_addr == REG_MAX_AGE) max_age = cfg_wdata;
				else fade_start = cfg_wdata;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser) predict_sweep(s_axis_tdata[137:106]);
				else predict_report(s_axis_tdata);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				track_result_t e;
				if (expected_results.size() == 0) begin
					$error("unexpected result word slot=%0d", m_axis_tdata[5:0]);
					fail_count++;
				end else begin
					e = expected_results.pop_front();
					if (m_axis_tuser !== e.status) begin
						$error("status exp %0d got %0d", e.status, m_axis_tuser);
						fail_count++;
					end
					if (m_axis_tdata[5:0] !== e.slot) begin
						$error("slot exp %0d got %0d", e.slot, m_axis_tdata[5:0]);
						fail_count++;
					end
					if (m_axis_tdata[14:6] !== e.alpha) begin
						$error("alpha exp %0d got %0d", e.alpha, m_axis_tdata[14:6]);
						fail_count++;
					end
					if (m_axis_tdata[20:15] !== e.fill) begin
						$error("trail_count exp %0d got %0d", e.fill, m_axis_tdata[20:15]);
						fail_count++;
					end
					if (m_axis_tdata[27:21] !== e.live) begin
						$error("active_count exp %0d got %0d", e.live, m_axis_tdata[27:21]);
						fail_count++;
					end
					if (m_axis_tdata[59:28] !== e.seen) begin
						$error("seen_total exp %0d got %0d", e.seen, m_axis_tdata[59:28]);
						fail_count++;
					end
					if (m_axis_tlast !== e.last) begin
						$error("last exp %0d got %0d", e.last, m_axis_tlast);
						fail_count++;
					end
				end
			end
		end
	end

endmodule

/* verif/keyed_track_table_with_aging_core_tb.sv */
`timescale 1ns / 100ps
module keyed_track_table_with_aging_core_tb;
	import kta_pkg::*;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [2:0]             m_axis_tuser;
	logic                   m_axis_tlast;
	logic                   cfg_we;
	logic                   cfg_addr;
	logic [CFG_W-1:0]       cfg_wdata;
	int                     fail_count;
	int                     pending_results;
	logic                   long_hold;
	logic [TIME_W-1:0]      clock_ms;
	logic [KEY_W-1:0]       key_pool [8];

	keyed_track_table_with_aging_core dut (.*);
	keyed_track_table_with_aging_core_chk chk (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	// receiver stall pattern, with one long hold-off on request
	initial begin
		bit held;
		held = 1'b0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold && !held) begin
				held = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (600) @(negedge clk);
			end else begin
				case ($urandom_range(0, 3))
					0: m_axis_tready <= 1'b0;
					1: m_axis_tready <= ($urandom_range(0, 3) != 0);
					default: m_axis_tready <= 1'b1;
				endcase
			end
		end
	end

	task automatic send_word(input logic sweep, input logic [KEY_W-1:0] k,
			input logic pos, input logic [LAT_W-1:0] lat, input logic [LON_W-1:0] lon,
			input logic [ALT_W-1:0] alt, input logic [TIME_W-1:0] ts);
		if ($urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 12)) @(negedge clk);
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= sweep;
		s_axis_tdata <= {6'd0, ts, alt, lon, lat, pos, k};
		// ready only moves at the rising edge, so check it between edges
		while (!s_axis_tready) @(negedge clk);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
	endtask

	task automatic report_at(input logic [KEY_W-1:0] k, input logic [TIME_W-1:0] ts);
		send_word(1'b0, k, 1'($urandom_range(0, 1)), LAT_W'($urandom), $urandom,
			ALT_W'($urandom), ts);
	endtask

	task automatic set_reg(input logic idx, input logic [CFG_W-1:0] v);
		while (pending_results != 0) @(negedge clk);
		repeat (300) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = REG_MAX_AGE;
		cfg_wdata = '0;
		long_hold = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: field extremes, update, sweep at default settings
		send_word(1'b0, 24'hFFFFFF, 1'b1, 31'h7FFFFFFF, '1, '1, 32'hFFFFFFFF);
		send_word(1'b0, 24'h000000, 1'b1, '0, '0, '0, 32'd0);
		send_word(1'b0, 24'hFFFFFF, 1'b0, '0, '0, '0, 32'd40000);
		send_word(1'b0, 24'h000000, 1'b1, 31'h12345678, 32'h80000000, 18'h20000, 32'd0);
		send_word(1'b1, '0, 1'b0, '0, '0, '0, 32'd45000);
		send_word(1'b1, '1, 1'b1, '1, '1, '1, 32'd70000);
		// fill table and overflow it
		for (int i = 0; i < 66; i++)
			report_at(KEY_W'(24'h100 + i), 32'd100000);
		send_word(1'b1, '0, 1'b0, '0, '0, '0, 32'd100500);

		// max_age at or below fade_start uses the default window
		set_reg(REG_MAX_AGE, 20'd500);
		set_reg(REG_FADE_START, 20'd0);
		send_word(1'b1, '0, 1'b0, '0, '0, '0, 32'd100300);
		set_reg(REG_MAX_AGE, 20'd0);
		send_word(1'b1, '0, 1'b0, '0, '0, '0, 32'd100300);
		set_reg(REG_MAX_AGE, 20'hFFFFF);
		set_reg(REG_FADE_START, 20'hFFFFF);

		// long receiver hold-off while reports keep coming
		long_hold = 1'b1;
		for (int i = 0; i < 6; i++) report_at(KEY_W'($urandom), 32'd200000);
		long_hold = 1'b0;

		set_reg(REG_MAX_AGE, 20'd5000);
		set_reg(REG_FADE_START, 20'd1000);
		for (int i = 0; i < 8; i++) key_pool[i] = KEY_W'($urandom);
		clock_ms = 32'hFFFF_F000;
		// random tracks with time moving forward across the wrap
		for (int i = 0; i < 150; i++) begin
			clock_ms += $urandom_range(0, 400);
			if (i == 75) begin
				set_reg(REG_MAX_AGE, 20'd600000);
				set_reg(REG_FADE_START, 20'd2000);
			end
			case ($urandom_range(0, 9))
				0: send_word(1'b1, KEY_W'($urandom), 1'($urandom), LAT_W'($urandom),
					$urandom, ALT_W'($urandom), clock_ms);
				1: report_at(KEY_W'($urandom), $urandom);
				default: report_at(key_pool[$urandom_range(0, 7)], clock_ms);
			endcase
		end
		send_word(1'b1, '0, 1'b0, '0, '0, '0, clock_ms + 32'd3000);

		while (pending_results != 0) @(negedge clk);
		repeat (300) @(negedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
